// File: rtl/pmrb_pkg.sv
// Package: shared types, constants and the arctangent table for the range binner.
package pmrb_pkg;

  localparam int NumBins    = 360;
  localparam int BinW       = 9;
  localparam int CoordW     = 16;
  localparam int RangeW     = 15;
  localparam int StoreW     = 16;
  localparam int CordicSteps = 16;
  localparam int StepW      = 4;
  localparam int AngW       = 32;
  localparam int CxW        = 19;
  localparam int SqW        = 31;
  localparam int RootW      = 16;
  localparam logic [StoreW-1:0] EmptyMark = 16'hFFFF;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRead   = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CfgMapRange  = 1'b0,
    CfgMaxHeight = 1'b1
  } cfg_idx_e;

  // Point unit sequencing
  typedef enum logic [1:0] {
    PuIdle,
    PuGate,
    PuIter,
    PuBin
  } pu_state_e;

  // Request from the datapath to the bin store
  typedef struct packed {
    logic            valid;
    logic            is_read;
    logic [BinW-1:0] bin;
    logic [RangeW:0] range_mm;
  } bin_req_t;

  function automatic logic [AngW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic [AngW-1:0] r;
    case (i)
      4'd0:  r = 32'h20000000;
      4'd1:  r = 32'h12E4051E;
      4'd2:  r = 32'h09FB385B;
      4'd3:  r = 32'h051111D4;
      4'd4:  r = 32'h028B0D43;
      4'd5:  r = 32'h0145D7E1;
      4'd6:  r = 32'h00A2F61E;
      4'd7:  r = 32'h00517C55;
      4'd8:  r = 32'h0028BE53;
      4'd9:  r = 32'h00145F2F;
      4'd10: r = 32'h000A2F98;
      4'd11: r = 32'h000517CC;
      4'd12: r = 32'h00028BE6;
      4'd13: r = 32'h000145F3;
      4'd14: r = 32'h0000A2FA;
      default: r = 32'h0000517D;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/pmrb_point_unit.sv
// Point unit: range gate, iterative CORDIC bearing and iterative square root.
module pmrb_point_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [pmrb_pkg::CoordW-1:0] x_i,
  input  logic signed [pmrb_pkg::CoordW-1:0] y_i,
  input  logic signed [pmrb_pkg::CoordW-1:0] z_i,
  input  logic [pmrb_pkg::RangeW-1:0]    map_range_i,
  input  logic signed [pmrb_pkg::CoordW-1:0] max_height_i,
  output logic                           busy_o,
  output pmrb_pkg::bin_req_t             req_o
);
  import pmrb_pkg::*;

  pu_state_e state_q, state_d;
  logic [StepW-1:0]     step_q, step_d;
  logic signed [CxW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [AngW:0]  ang_q, ang_d;
  logic [SqW:0]          d2_q, d2_d, rem_q, rem_d;
  logic [RootW-1:0]      root_q, root_d;
  logic                  keep_q, keep_d;
  logic signed [CoordW:0] ax_q, ay_q, ax_d, ay_d;
  logic [SqW:0]          lim_q, lim_d;
  logic [AngW+BinW-1:0]  prod_q, prod_d;
  bin_req_t              req_d;

  logic signed [CxW-1:0] dx, dy;
  logic [AngW-1:0]       phase;
  logic [AngW+BinW:0]    scaled;
  logic [BinW-1:0]       bin_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PuIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;  cx_q <= cx_d;  cy_q <= cy_d;  ang_q <= ang_d;
    d2_q <= d2_d;  rem_q <= rem_d;  root_q <= root_d;  keep_q <= keep_d;
    ax_q <= ax_d;  ay_q <= ay_d;  lim_q <= lim_d;  prod_q <= prod_d;
  end

  assign dx    = cy_q >>> step_q;
  assign dy    = cx_q >>> step_q;
  assign phase = ang_q[AngW-1:0] + 32'h80000000;
  assign scaled = {1'b0, prod_q} + 42'h080000000;
  assign bin_w  = (scaled[AngW+BinW-1:AngW] >= BinW'(NumBins)) ?
                  BinW'(scaled[AngW+BinW-1:AngW] - BinW'(NumBins)) :
                  scaled[AngW+BinW-1:AngW];

  always_comb begin
    logic [SqW:0] cand;
    logic [RootW-1:0] rsh;
    state_d = state_q;  step_d = step_q;  cx_d = cx_q;  cy_d = cy_q;
    ang_d = ang_q;  d2_d = d2_q;  rem_d = rem_q;  root_d = root_q;
    keep_d = keep_q;  ax_d = ax_q;  ay_d = ay_q;  lim_d = lim_q;
    prod_d = prod_q;
    req_d = '0;
    cand = '0;
    rsh = '0;
    unique case (state_q)
      PuIdle: begin
        if (start_i) begin
          ax_d = x_i[CoordW-1] ? -(CoordW+1)'(x_i) : (CoordW+1)'(x_i);
          ay_d = y_i[CoordW-1] ? -(CoordW+1)'(y_i) : (CoordW+1)'(y_i);
          lim_d = (SqW+1)'(map_range_i) * (SqW+1)'(map_range_i);
          keep_d = z_i < max_height_i;
          step_d = '0;
          if (x_i[CoordW-1] && !y_i[CoordW-1]) begin
            cx_d = CxW'(y_i);  cy_d = -CxW'(x_i);  ang_d = 33'sh040000000;
          end else if (x_i[CoordW-1]) begin
            cx_d = -CxW'(y_i); cy_d = CxW'(x_i);  ang_d = -33'sh040000000;
          end else begin
            cx_d = CxW'(x_i);  cy_d = CxW'(y_i);  ang_d = '0;
          end
          state_d = PuGate;
        end
      end
      PuGate: begin
        // magnitudes reach 32768, so square them at full width
        d2_d = (SqW+1)'($unsigned(ax_q)) * (SqW+1)'($unsigned(ax_q)) +
               (SqW+1)'($unsigned(ay_q)) * (SqW+1)'($unsigned(ay_q));
        rem_d = d2_d;
        root_d = '0;
        state_d = PuIter;
      end
      PuIter: begin
        if (step_q == '0 && (!keep_q || d2_q >= lim_q)) begin
          state_d = PuIdle;
        end else begin
          // CORDIC vectoring step
          if (!cy_q[CxW-1]) begin
            cx_d = cx_q + dx;  cy_d = cy_q - dy;
            ang_d = ang_q + $signed({1'b0, atan_lut(step_q)});
          end else begin
            cx_d = cx_q - dx;  cy_d = cy_q + dy;
            ang_d = ang_q - $signed({1'b0, atan_lut(step_q)});
          end
          // restoring square root step for result bit 15-step
          rsh = root_q | (RootW'(1) << (4'd15 - step_q));
          cand = (SqW+1)'(rsh) * (SqW+1)'(rsh);
          if (cand <= rem_q) root_d = rsh;
          step_d = step_q + 1'b1;
          if (step_q == StepW'(CordicSteps - 1)) state_d = PuBin;
        end
      end
      PuBin: begin
        if (!keep_q) begin
          prod_d = (AngW+BinW)'(phase) * (AngW+BinW)'(NumBins);
          keep_d = 1'b1;
        end else begin
          req_d.valid = 1'b1;
          req_d.bin = bin_w;
          req_d.range_mm = (RangeW+1)'(root_q);
          state_d = PuIdle;
        end
      end
      default: state_d = PuIdle;
    endcase
    if (state_q == PuIter && state_d == PuBin) keep_d = 1'b0;
  end

  assign busy_o = (state_q != PuIdle);
  assign req_o  = req_d;

  logic unused;
  assign unused = scaled[AngW+BinW];
endmodule

// File: rtl/pmrb_bin_store.sv
// Bin store: minimum-range memory with read-modify-write and clearing pass.
module pmrb_bin_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pmrb_pkg::bin_req_t          req_i,
  output logic                        clearing_o,
  output logic                        busy_o,
  output logic                        rd_valid_o,
  output logic [pmrb_pkg::RangeW-1:0] rd_range_o
);
  import pmrb_pkg::*;

  logic [StoreW-1:0] mem [NumBins];
  logic [StoreW-1:0] rdata_q;
  logic [BinW-1:0]   clr_q;
  logic              clearing_q;
  logic              ph_q, is_read_q;
  logic [BinW-1:0]   bin_q;
  logic [RangeW:0]   dist_q;
  logic              wr_en;
  logic [BinW-1:0]   wr_addr;
  logic [StoreW-1:0] wr_data;

  // clear sweep after reset, then pending modify phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q <= '0;
      ph_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == BinW'(NumBins - 1)) clearing_q <= 1'b0;
      end
      ph_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      bin_q <= req_i.bin;
      dist_q <= req_i.range_mm;
      is_read_q <= req_i.is_read;
    end
  end

  always_comb begin
    wr_en = 1'b0;  wr_addr = bin_q;  wr_data = EmptyMark;
    if (clearing_q) begin
      wr_en = 1'b1;  wr_addr = clr_q;
    end else if (ph_q) begin
      if (is_read_q) begin
        wr_en = 1'b1;
      end else if (StoreW'(dist_q) < rdata_q) begin
        wr_en = 1'b1;  wr_data = StoreW'(dist_q);
      end
    end
  end

  // memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (req_i.valid) rdata_q <= mem[req_i.bin];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  assign clearing_o = clearing_q;
  assign busy_o     = ph_q;
  assign rd_valid_o = ph_q && is_read_q;
  assign rd_range_o = (rdata_q == EmptyMark) ? '0 : rdata_q[RangeW-1:0];
endmodule

// File: rtl/polar_min_range_binning.sv
// Top level: stream wrapper around the point unit and bin store.
// A kept insert holds off the next request until it has passed accept, the
// gate, 16 shared CORDIC and root steps, bin scaling and the bin request,
// then the memory read and the write back; an insert dropped by the height
// or range gate frees the input without the CORDIC and root steps. An
// in-range read passes through the memory read register into the output
// register, an out-of-range read places a zero result there at acceptance;
// no request is taken while a result waits there. A clearing pass over all
// 360 bins follows reset, during which no request is taken.
module polar_min_range_binning (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_mm, y_mm, z_mm, bin_index
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // range_mm, bin_echo
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pmrb_pkg::*;

  logic [RangeW-1:0]        map_range_q;
  logic signed [CoordW-1:0] max_height_q;
  logic                     busy_q;
  logic [BinW-1:0]          echo_q, echo_out_q;
  logic [RangeW-1:0]        range_out_q;
  logic                     out_valid_q;
  logic                     pu_busy, st_clear, st_busy, rd_valid;
  logic [RangeW-1:0]        rd_range;
  bin_req_t                 pu_req, rd_req, st_req;
  logic                     accept, is_read, in_range;
  logic [BinW-1:0]          bin_in;
  logic                     unused_pad;

  assign bin_in   = s_axis_tdata[56:48];
  assign unused_pad = ^s_axis_tdata[63:57];
  assign is_read  = (s_axis_tuser == CmdRead);
  assign in_range = bin_in < BinW'(NumBins);
  assign s_axis_tready = !st_clear && !busy_q && !pu_busy && !st_busy && !out_valid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_range_q <= 15'd8000;
      max_height_q <= 16'sd32767;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMapRange) map_range_q <= cfg_data_i[RangeW-1:0];
      else max_height_q <= cfg_data_i;
    end
  end

  pmrb_point_unit u_pu (
    .clk_i, .rst_ni,
    .start_i(accept && !is_read),
    .x_i(s_axis_tdata[15:0]), .y_i(s_axis_tdata[31:16]),
    .z_i(s_axis_tdata[47:32] & 16'hFFFF),
    .map_range_i(map_range_q), .max_height_i(max_height_q),
    .busy_o(pu_busy), .req_o(pu_req)
  );

  always_comb begin
    rd_req = '0;
    rd_req.valid = accept && is_read && in_range;
    rd_req.is_read = 1'b1;
    rd_req.bin = bin_in;
    st_req = rd_req.valid ? rd_req : pu_req;
  end

  pmrb_bin_store u_st (
    .clk_i, .rst_ni, .req_i(st_req), .clearing_o(st_clear),
    .busy_o(st_busy), .rd_valid_o(rd_valid), .rd_range_o(rd_range)
  );

  // track a read in flight and drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      echo_q <= '0;
      echo_out_q <= '0;
      range_out_q <= '0;
    end else begin
      if (accept && is_read) begin
        if (in_range) begin
          busy_q <= 1'b1;
          echo_q <= bin_in;
        end else begin
          out_valid_q <= 1'b1;  range_out_q <= '0;
          echo_out_q <= bin_in;
        end
      end else if (rd_valid) begin
        out_valid_q <= 1'b1;  range_out_q <= rd_range;
        echo_out_q <= echo_q;  busy_q <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {echo_out_q, range_out_q};

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_clear |-> !s_axis_tready) else $error("request taken during clear");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid |=> m_axis_tvalid) else $error("read result lost");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pu_req.valid && rd_req.valid) |-> 1'b0) else $error("store request clash");
endmodule
